>>> rtl/core/jpcl_pkg.sv
// Shared types, constants and helpers for the joint position command limiter.
// No dependencies; imported by the front, back and top level.
package jpcl_pkg;

   // width of signed intermediate positions and velocities
   localparam int WW = 50;
   typedef logic signed [WW-1:0] wide_type;

   localparam wide_type POS_MAX_W = 50'sd2147483647;
   localparam wide_type POS_MIN_W = -50'sd2147483648;
   localparam logic signed [31:0] POS_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] POS_MIN = 32'sh8000_0000;

   // configuration register indexes
   localparam logic [1:0] CSR_LEAD  = 2'd0;
   localparam logic [1:0] CSR_STIME = 2'd1;
   localparam logic [1:0] CSR_SRATE = 2'd2;

   // result status codes
   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_REJECT = 2'd1;
   localparam logic [1:0] ST_EMPTY  = 2'd2;

   typedef enum logic [1:0] {
      OP_STEP  = 2'd0,
      OP_INIT  = 2'd1,
      OP_LOAD  = 2'd2,
      OP_QUERY = 2'd3
   } kind_type;

   // classified word passed from front to back
   typedef struct packed {
      kind_type           op;
      logic               joint_ok;
      logic [2:0]         joint;
      logic signed [31:0] meas;
      logic signed [31:0] req;
      logic [30:0]        spd;
      logic signed [31:0] lo;
      logic signed [31:0] hi;
   } item_type;

   // saturate a wide signed value to 32 bits
   function automatic logic signed [31:0] sat32(input wide_type v);
      logic signed [31:0] r;
      if (v > POS_MAX_W) begin
         r = POS_MAX;
      end else if (v < POS_MIN_W) begin
         r = POS_MIN;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

>>> rtl/core/jpcl_front.sv
// Front end: accepts request words, classifies them and queues them.
// Depends on jpcl_pkg.
module jpcl_front
   import jpcl_pkg::*;
#(
   parameter int JOINTS = 7
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_kind,
   input  logic [2:0]         req_joint,
   input  logic signed [31:0] req_measured_position,
   input  logic signed [31:0] req_requested_velocity,
   input  logic [30:0]        req_speed_limit,
   input  logic signed [31:0] req_lower_bound,
   input  logic signed [31:0] req_upper_bound,
   output logic               q_valid,
   output item_type           q_item,
   input  logic               q_pop
);

   item_type   slot_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] cnt_ff;
   logic       push;
   item_type   cls;

   // classify the incoming word
   always_comb begin
      cls.op       = kind_type'(req_kind);
      cls.joint_ok = (int'(req_joint) < JOINTS);
      cls.joint    = req_joint;
      cls.meas     = req_measured_position;
      cls.req      = req_requested_velocity;
      cls.spd      = req_speed_limit;
      cls.lo       = req_lower_bound;
      cls.hi       = req_upper_bound;
   end

   assign req_stall = (cnt_ff == 2'd2);
   assign push      = req_valid && !req_stall;
   assign q_valid   = (cnt_ff != 2'd0);
   assign q_item    = slot_ff[rd_ptr_ff];

   // store payload
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= cls;
      end
   end

   // advance pointers and count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (q_pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         cnt_ff <= cnt_ff + 2'(push) - 2'(q_pop);
      end
   end

endmodule

>>> rtl/core/jpcl_back.sv
// Back end: per-joint state, shared scale unit and result register.
// Depends on jpcl_pkg.
module jpcl_back
   import jpcl_pkg::*;
#(
   parameter int JOINTS = 7
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_valid,
   input  item_type           q_item,
   output logic               q_pop,
   input  logic [30:0]        lead_limit,
   input  logic [24:0]        step_time,
   input  logic [31:0]        step_rate,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [2:0]         rsp_joint_echo,
   output logic [1:0]         rsp_status,
   output logic signed [31:0] rsp_command_before,
   output logic signed [31:0] rsp_cmd_after,
   output logic signed [31:0] rsp_clipped_velocity,
   output logic signed [31:0] rsp_effective_velocity,
   output logic               rsp_speed_capped,
   output logic               rsp_lead_capped,
   output logic               rsp_range_capped,
   output logic signed [31:0] rsp_bound_low,
   output logic signed [31:0] rsp_bound_high
);

   localparam int JW = (JOINTS > 1) ? $clog2(JOINTS) : 1;

   typedef enum logic [3:0] {
      S_IDLE, S_DECODE, S_QPREP, S_MUL, S_RND, S_POST,
      S_LEAD, S_RANGE, S_VSET, S_QEND, S_OUT
   } state_type;

   typedef enum logic [1:0] {
      PH_STEP_INT, PH_STEP_VEL, PH_Q_LOW, PH_Q_HIGH
   } phase_type;

   state_type state_ff;
   phase_type ph_ff;

   logic signed [31:0] cmd_mem_ff [JOINTS];
   logic [30:0]        spd_mem_ff [JOINTS];
   logic signed [31:0] lo_mem_ff  [JOINTS];
   logic signed [31:0] hi_mem_ff  [JOINTS];

   item_type           it_ff;
   logic [JW-1:0]      jidx_ff;
   logic signed [31:0] cmd_ff;
   logic [30:0]        spd_ff;
   logic signed [31:0] lo_ff, hi_ff;
   logic signed [31:0] clip_ff, after_ff, eff_ff, bl_ff, bh_ff;
   logic               ssat_ff, lfl_ff, rc_ff;
   logic [1:0]         status_ff;
   wide_type           integ_ff, led_ff, cl_ff, cu_ff, vl_ff, vu_ff, sx_ff, rnd_ff;
   logic [31:0]        sk_ff;
   logic               neg_ff;
   logic [63:0]        mlo_ff;
   logic [34:0]        mhi_ff;

   logic [2:0]         out_joint_ff;
   logic [1:0]         out_status_ff;
   logic signed [31:0] out_before_ff, out_after_ff, out_clip_ff, out_eff_ff;
   logic signed [31:0] out_bl_ff, out_bh_ff;
   logic               out_ssat_ff, out_lfl_ff, out_rc_ff, out_valid_ff;

   // working values
   logic [JW-1:0]      jidx;
   wide_type           spd_w, meas_w, lead_w, cmd_w, lo_w, hi_w, mag;
   wide_type           t1, t2, lo_b, hi_b;
   logic [67:0]        prod_sum;
   logic [47:0]        r_mag;
   logic signed [31:0] nspd, clip_c;
   logic               out_free;

   assign jidx     = JW'(q_item.joint);
   assign spd_w    = wide_type'({19'b0, spd_ff});
   assign meas_w   = wide_type'(it_ff.meas);
   assign lead_w   = wide_type'({19'b0, lead_limit});
   assign cmd_w    = wide_type'(cmd_ff);
   assign lo_w     = wide_type'(lo_ff);
   assign hi_w     = wide_type'(hi_ff);
   assign lo_b     = meas_w - lead_w;
   assign hi_b     = meas_w + lead_w;
   assign mag      = sx_ff[WW-1] ? -sx_ff : sx_ff;
   assign prod_sum = {1'b0, mhi_ff, 32'b0} + {4'b0, mlo_ff} + 68'h80000;
   assign r_mag    = prod_sum[67:20];
   assign nspd     = -$signed({1'b0, spd_ff});
   assign out_free = !out_valid_ff || !rsp_stall;
   assign q_pop    = (state_ff == S_IDLE) && q_valid;

   // clamp request to speed limit
   always_comb begin
      if (it_ff.req < nspd) begin
         clip_c = nspd;
      end else if (it_ff.req > $signed({1'b0, spd_ff})) begin
         clip_c = $signed({1'b0, spd_ff});
      end else begin
         clip_c = it_ff.req;
      end
   end

   // position range clamp on the lead-limited command
   always_comb begin
      t1 = (lo_ff != POS_MIN && led_ff < lo_w) ? lo_w : led_ff;
      t2 = (hi_ff != POS_MAX && t1 > hi_w) ? hi_w : t1;
   end

   // sequencer, joint state and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ph_ff        <= PH_STEP_INT;
         out_valid_ff <= 1'b0;
         for (int i = 0; i < JOINTS; i++) begin
            cmd_mem_ff[i] <= 32'sd0;
            spd_mem_ff[i] <= 31'h7FFF_FFFF;
            lo_mem_ff[i]  <= POS_MIN;
            hi_mem_ff[i]  <= POS_MAX;
         end
      end else begin
         // drop the taken result unless a new one loads this cycle
         if (out_valid_ff && !rsp_stall && state_ff != S_OUT) begin
            out_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (q_valid) begin
                  it_ff     <= q_item;
                  jidx_ff   <= jidx;
                  cmd_ff    <= q_item.joint_ok ? cmd_mem_ff[jidx] : 32'sd0;
                  after_ff  <= q_item.joint_ok ? cmd_mem_ff[jidx] : 32'sd0;
                  spd_ff    <= spd_mem_ff[jidx];
                  lo_ff     <= lo_mem_ff[jidx];
                  hi_ff     <= hi_mem_ff[jidx];
                  clip_ff   <= 32'sd0;
                  eff_ff    <= 32'sd0;
                  bl_ff     <= 32'sd0;
                  bh_ff     <= 32'sd0;
                  ssat_ff   <= 1'b0;
                  lfl_ff    <= 1'b0;
                  rc_ff     <= 1'b0;
                  status_ff <= ST_OK;
                  state_ff  <= S_DECODE;
               end
            end
            S_DECODE: begin
               if (!it_ff.joint_ok) begin
                  state_ff <= S_OUT;
               end else begin
                  unique case (it_ff.op)
                     OP_STEP: begin
                        clip_ff  <= clip_c;
                        ssat_ff  <= (clip_c != it_ff.req);
                        sx_ff    <= wide_type'(clip_c);
                        sk_ff    <= 32'(step_time);
                        ph_ff    <= PH_STEP_INT;
                        state_ff <= S_MUL;
                     end
                     OP_INIT: begin
                        cmd_mem_ff[jidx_ff] <= it_ff.meas;
                        after_ff            <= it_ff.meas;
                        state_ff            <= S_OUT;
                     end
                     OP_LOAD: begin
                        if (it_ff.spd == 31'd0 || it_ff.lo > it_ff.hi) begin
                           status_ff <= ST_REJECT;
                        end else begin
                           spd_mem_ff[jidx_ff] <= it_ff.spd;
                           lo_mem_ff[jidx_ff]  <= it_ff.lo;
                           hi_mem_ff[jidx_ff]  <= it_ff.hi;
                        end
                        state_ff <= S_OUT;
                     end
                     default: begin
                        cl_ff    <= (lo_ff != POS_MIN && lo_w > lo_b) ? lo_w : lo_b;
                        cu_ff    <= (hi_ff != POS_MAX && hi_w < hi_b) ? hi_w : hi_b;
                        state_ff <= S_QPREP;
                     end
                  endcase
               end
            end
            S_QPREP: begin
               sx_ff    <= cl_ff - cmd_w;
               sk_ff    <= step_rate;
               ph_ff    <= PH_Q_LOW;
               state_ff <= S_MUL;
            end
            S_MUL: begin
               neg_ff   <= sx_ff[WW-1];
               mlo_ff   <= 64'(mag[31:0]) * 64'(sk_ff);
               mhi_ff   <= 35'(mag[34:32]) * 35'(sk_ff);
               state_ff <= S_RND;
            end
            S_RND: begin
               rnd_ff   <= neg_ff ? -wide_type'({2'b0, r_mag}) : wide_type'({2'b0, r_mag});
               state_ff <= S_POST;
            end
            S_POST: begin
               unique case (ph_ff)
                  PH_STEP_INT: begin
                     integ_ff <= cmd_w + rnd_ff;
                     state_ff <= S_LEAD;
                  end
                  PH_STEP_VEL: begin
                     eff_ff   <= sat32(rnd_ff);
                     state_ff <= S_OUT;
                  end
                  PH_Q_LOW: begin
                     vl_ff    <= (rnd_ff < -spd_w) ? -spd_w : rnd_ff;
                     sx_ff    <= cu_ff - cmd_w;
                     ph_ff    <= PH_Q_HIGH;
                     state_ff <= S_MUL;
                  end
                  default: begin
                     vu_ff    <= (rnd_ff > spd_w) ? spd_w : rnd_ff;
                     state_ff <= S_QEND;
                  end
               endcase
            end
            S_LEAD: begin
               if (integ_ff < lo_b) begin
                  led_ff <= lo_b;
                  lfl_ff <= 1'b1;
               end else if (integ_ff > hi_b) begin
                  led_ff <= hi_b;
                  lfl_ff <= 1'b1;
               end else begin
                  led_ff <= integ_ff;
               end
               state_ff <= S_RANGE;
            end
            S_RANGE: begin
               after_ff <= sat32(t2);
               rc_ff    <= (t2 != led_ff);
               state_ff <= S_VSET;
            end
            S_VSET: begin
               cmd_mem_ff[jidx_ff] <= after_ff;
               sx_ff    <= wide_type'(after_ff) - cmd_w;
               sk_ff    <= step_rate;
               ph_ff    <= PH_STEP_VEL;
               state_ff <= S_MUL;
            end
            S_QEND: begin
               status_ff <= (vl_ff > vu_ff) ? ST_EMPTY : ST_OK;
               bl_ff     <= sat32(vl_ff);
               bh_ff     <= sat32(vu_ff);
               state_ff  <= S_OUT;
            end
            S_OUT: begin
               if (out_free) begin
                  out_valid_ff  <= 1'b1;
                  out_joint_ff  <= it_ff.joint;
                  out_status_ff <= status_ff;
                  out_before_ff <= cmd_ff;
                  out_after_ff  <= after_ff;
                  out_clip_ff   <= clip_ff;
                  out_eff_ff    <= eff_ff;
                  out_ssat_ff   <= ssat_ff;
                  out_lfl_ff    <= lfl_ff;
                  out_rc_ff     <= rc_ff;
                  out_bl_ff     <= bl_ff;
                  out_bh_ff     <= bh_ff;
                  state_ff      <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid              = out_valid_ff;
   assign rsp_joint_echo         = out_joint_ff;
   assign rsp_status             = out_status_ff;
   assign rsp_command_before     = out_before_ff;
   assign rsp_cmd_after          = out_after_ff;
   assign rsp_clipped_velocity   = out_clip_ff;
   assign rsp_effective_velocity = out_eff_ff;
   assign rsp_speed_capped       = out_ssat_ff;
   assign rsp_lead_capped        = out_lfl_ff;
   assign rsp_range_capped       = out_rc_ff;
   assign rsp_bound_low          = out_bl_ff;
   assign rsp_bound_high         = out_bh_ff;

endmodule

>>> rtl/core/joint_position_command_limiter.sv
// Joint position command limiter: per-joint velocity and position limited
// command integrator. Request words enter on req_*, one result word per
// request leaves on rsp_*; csr_* writes the lead limit, step time and rate.
// A word is taken at a rising edge with valid high and stall low.
// The front queues up to two classified request words while the back works.
// In the back an invalid joint, an init or a load goes from decode straight
// to output; a step makes two passes through the shared multiply and round
// unit, and a query makes two passes as well. The back works on one word at
// a time and takes no new word until the single shared scale unit is done.
// Results sit in an output register; while rsp_stall is high the result
// holds and the back waits at its end, then the front queue fills and
// req_stall rises. Synchronous reset empties the queue, drops any result,
// sets every joint to command 0 with unlimited range and largest speed,
// and loads the register reset values.
// Depends on jpcl_pkg, jpcl_front and jpcl_back.
module joint_position_command_limiter
   import jpcl_pkg::*;
#(
   parameter int JOINTS = 7
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write_en,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_wdata,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_kind,
   input  logic [2:0]         req_joint,
   input  logic signed [31:0] req_measured_position,
   input  logic signed [31:0] req_requested_velocity,
   input  logic [30:0]        req_speed_limit,
   input  logic signed [31:0] req_lower_bound,
   input  logic signed [31:0] req_upper_bound,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [2:0]         rsp_joint_echo,
   output logic [1:0]         rsp_status,
   output logic signed [31:0] rsp_command_before,
   output logic signed [31:0] rsp_cmd_after,
   output logic signed [31:0] rsp_clipped_velocity,
   output logic signed [31:0] rsp_effective_velocity,
   output logic               rsp_speed_capped,
   output logic               rsp_lead_capped,
   output logic               rsp_range_capped,
   output logic signed [31:0] rsp_bound_low,
   output logic signed [31:0] rsp_bound_high
);

   logic [30:0] lead_ff;
   logic [24:0] stime_ff;
   logic [31:0] srate_ff;
   logic        q_valid;
   logic        q_pop;
   item_type    q_item;

   // hold configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         lead_ff  <= 31'd8388608;
         stime_ff <= 25'd16777;
         srate_ff <= 32'd65536000;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_LEAD:  lead_ff  <= csr_wdata[30:0];
            CSR_STIME: stime_ff <= csr_wdata[24:0];
            CSR_SRATE: srate_ff <= csr_wdata;
            default:   ;
         endcase
      end
   end

   jpcl_front #(.JOINTS(JOINTS)) u_front (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_stall              (req_stall),
      .req_kind               (req_kind),
      .req_joint              (req_joint),
      .req_measured_position  (req_measured_position),
      .req_requested_velocity (req_requested_velocity),
      .req_speed_limit        (req_speed_limit),
      .req_lower_bound        (req_lower_bound),
      .req_upper_bound        (req_upper_bound),
      .q_valid                (q_valid),
      .q_item                 (q_item),
      .q_pop                  (q_pop)
   );

   jpcl_back #(.JOINTS(JOINTS)) u_back (
      .clock                  (clock),
      .reset                  (reset),
      .q_valid                (q_valid),
      .q_item                 (q_item),
      .q_pop                  (q_pop),
      .lead_limit             (lead_ff),
      .step_time              (stime_ff),
      .step_rate              (srate_ff),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_joint_echo         (rsp_joint_echo),
      .rsp_status             (rsp_status),
      .rsp_command_before     (rsp_command_before),
      .rsp_cmd_after          (rsp_cmd_after),
      .rsp_clipped_velocity   (rsp_clipped_velocity),
      .rsp_effective_velocity (rsp_effective_velocity),
      .rsp_speed_capped       (rsp_speed_capped),
      .rsp_lead_capped        (rsp_lead_capped),
      .rsp_range_capped       (rsp_range_capped),
      .rsp_bound_low          (rsp_bound_low),
      .rsp_bound_high         (rsp_bound_high)
   );

endmodule
